[src/dds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descending distance sorter package
// Record and channel types, capacity and index widths shared by the sorter.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int IDX_W       = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

   typedef struct packed {
      logic [31:0] distance_key;
      logic [15:0] position_x;
      logic [15:0] position_y;
      logic        last_in;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] sorted_key;
      logic [15:0] sorted_x;
      logic [15:0] sorted_y;
      logic        last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] x;
      logic [15:0] y;
   } record_type;

endpackage

[src/descending_distance_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descending distance sorter
// Collects records and emits them by distance key, greatest first, stable.
// ----------------------------------------------------------------------------
// Records arrive on the req_ channel as valid/ready transfers. Each record is
// placed by insertion into a record memory with one read and one write port:
// entries with a strictly smaller key move up one slot, one entry per cycle,
// so equal keys keep their arrival order. The first record of a set is written
// directly; any later record first reads its neighbour slot, then moves up each
// stored record it passes and takes the freed slot. req_ready is low meanwhile.
// Records beyond MAX_RECORDS are dropped; a dropped record marked last still
// closes the set.
// When the record marked last has been placed, the set is streamed out on the
// rsp_ channel, each record by a memory read, then the output register, the
// final record carrying last_out. The set is then empty. A stalled receiver
// holds the output register and pauses the stream; a new set may be loaded
// while the final result still waits. Synchronous reset empties the set and
// the output register; memory contents are not cleared.
// ----------------------------------------------------------------------------
module descending_distance_sorter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dds_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dds_pkg::rsp_payload_type rsp_data
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE      = 3'd0;
   localparam logic [ST_W-1:0] ST_LOOKUP    = 3'd1;
   localparam logic [ST_W-1:0] ST_SHIFT     = 3'd2;
   localparam logic [ST_W-1:0] ST_PLACE     = 3'd3;
   localparam logic [ST_W-1:0] ST_EMIT_READ = 3'd4;
   localparam logic [ST_W-1:0] ST_EMIT_LOAD = 3'd5;

   logic [ST_W-1:0]              state_ff, state_in;
   logic [dds_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [dds_pkg::IDX_W-1:0]    pos_ff, pos_in;
   logic [dds_pkg::IDX_W-1:0]    emit_ff, emit_in;
   logic                         closing_ff, closing_in;
   dds_pkg::record_type          new_ff, new_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dds_pkg::rsp_payload_type     rsp_ff, rsp_in;

   dds_pkg::record_type          record_mem_ff [dds_pkg::MAX_RECORDS];
   dds_pkg::record_type          rd_data_ff;
   logic                         rd_en;
   logic [dds_pkg::IDX_W-1:0]    rd_addr;
   logic                         wr_en;
   logic [dds_pkg::IDX_W-1:0]    wr_addr;
   dds_pkg::record_type          wr_data;

   logic                         req_fire;
   logic                         out_free;
   logic                         emit_last;
   logic                         emit_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = ({1'b0, emit_ff} + 1'b1) == count_ff;
   assign emit_load = (state_ff == ST_EMIT_LOAD) && out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      emit_in      = emit_ff;
      closing_in   = closing_ff;
      new_in       = new_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = emit_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = new_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_in.key = req_data.distance_key;
               new_in.x   = req_data.position_x;
               new_in.y   = req_data.position_y;
               closing_in = req_data.last_in;
               emit_in    = '0;
               if (count_ff < dds_pkg::CNT_W'(dds_pkg::MAX_RECORDS)) begin
                  pos_in   = count_ff[dds_pkg::IDX_W-1:0];
                  state_in = (count_ff == '0) ? ST_PLACE : ST_LOOKUP;
               end else if (req_data.last_in) begin
                  state_in = ST_EMIT_READ;
               end
            end
         end
         ST_LOOKUP: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff - 1'b1;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (rd_data_ff.key < new_ff.key) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - 1'b1;
               if (pos_ff == dds_pkg::IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - dds_pkg::IDX_W'(2);
               end
            end else begin
               count_in = count_ff + 1'b1;
               state_in = closing_ff ? ST_EMIT_READ : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = closing_ff ? ST_EMIT_READ : ST_IDLE;
         end
         ST_EMIT_READ: begin
            rd_en    = 1'b1;
            rd_addr  = emit_ff;
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.sorted_key   = rd_data_ff.key;
               rsp_in.sorted_x     = rd_data_ff.x;
               rsp_in.sorted_y     = rd_data_ff.y;
               rsp_in.last_out     = emit_last;
               if (emit_last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  state_in = ST_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         record_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= record_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      emit_ff    <= emit_in;
      closing_ff <= closing_in;
      new_ff     <= new_in;
      rsp_ff     <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= dds_pkg::CNT_W'(dds_pkg::MAX_RECORDS))
      else $error("Record count exceeds capacity.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (pos_ff != '0))
      else $error("Insertion shift reached slot zero.");

   assert property (@(posedge clock) disable iff (reset)
      (emit_load && emit_last) |=> (count_ff == '0) && (state_ff == ST_IDLE))
      else $error("Set not emptied after final result.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (count_ff < dds_pkg::CNT_W'(dds_pkg::MAX_RECORDS))) |=> !req_ready)
      else $error("Stored record did not start insertion.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("Stalled result changed.");
`endif

endmodule
